// ===== hdl/adsr_envelope_generator_defines.svh =====
// Assertion helpers shared by the envelope RTL.
// Both expect clk and rst_n to be in scope.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

  // Default fraction width (1.0 = 2**FRAC_BITS)
  localparam int FRAC_BITS_DEF = 24;

  // APB register port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  // Envelope stage codes
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  // Request codes of an input word
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2
  } req_t;

  // Register indexes (byte address / 4)
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_COEF   = 3'd0,
    REG_ATTACK_BASE   = 3'd1,
    REG_DECAY_COEF    = 3'd2,
    REG_DECAY_BASE    = 3'd3,
    REG_SUSTAIN_LEVEL = 3'd4,
    REG_RELEASE_COEF  = 3'd5,
    REG_RELEASE_BASE  = 3'd6,
    REG_LEAK_FACTOR   = 3'd7
  } reg_idx_t;

  // Operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MS_LEVEL_COEF = 2'd0,
    MS_PROD_LEAK  = 2'd1,
    MS_LEVEL_GAIN = 2'd2
  } mul_sel_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_MUL1   = 3'd1,
    S_MUL2   = 3'd2,
    S_UPD    = 3'd3,
    S_OUTMUL = 3'd4,
    S_WB     = 3'd5
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic     note_on;
    logic     note_off;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_en;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    stage_t stage;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/adsr_regs.sv =====
`default_nettype none

module adsr_regs #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [adsr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [adsr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output logic               [FRAC_BITS:0]      attack_coef,
  output logic               [FRAC_BITS:0]      attack_base,
  output logic               [FRAC_BITS:0]      decay_coef,
  output logic signed        [FRAC_BITS+1:0]    decay_base,
  output logic               [FRAC_BITS:0]      sustain_level,
  output logic               [FRAC_BITS:0]      release_coef,
  output logic signed        [FRAC_BITS:0]      release_base,
  output logic               [FRAC_BITS:0]      leak_factor
);
  import adsr_pkg::*;

  localparam int UW  = FRAC_BITS + 1;
  localparam int DBW = FRAC_BITS + 2;

  localparam logic [UW-1:0]         ONE_U  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [UW-1:0]         HALF_U = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [DBW-1:0] HALF_D = {3'b001, {(FRAC_BITS-1){1'b0}}};

  logic               [UW-1:0]  attack_coef_r;
  logic               [UW-1:0]  attack_base_r;
  logic               [UW-1:0]  decay_coef_r;
  logic signed        [DBW-1:0] decay_base_r;
  logic               [UW-1:0]  sustain_level_r;
  logic               [UW-1:0]  release_coef_r;
  logic signed        [UW-1:0]  release_base_r;
  logic               [UW-1:0]  leak_factor_r;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coef_r   <= '0;
      attack_base_r   <= ONE_U;
      decay_coef_r    <= '0;
      decay_base_r    <= HALF_D;
      sustain_level_r <= HALF_U;
      release_coef_r  <= '0;
      release_base_r  <= '0;
      leak_factor_r   <= ONE_U;
    end else if (wr_en) begin
      case (idx)
        REG_ATTACK_COEF:   attack_coef_r   <= pwdata[UW-1:0];
        REG_ATTACK_BASE:   attack_base_r   <= pwdata[UW-1:0];
        REG_DECAY_COEF:    decay_coef_r    <= pwdata[UW-1:0];
        REG_DECAY_BASE:    decay_base_r    <= signed'(pwdata[DBW-1:0]);
        REG_SUSTAIN_LEVEL: sustain_level_r <= pwdata[UW-1:0];
        REG_RELEASE_COEF:  release_coef_r  <= pwdata[UW-1:0];
        REG_RELEASE_BASE:  release_base_r  <= signed'(pwdata[UW-1:0]);
        REG_LEAK_FACTOR:   leak_factor_r   <= pwdata[UW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; signed registers read back sign-extended
  always_comb begin
    case (idx)
      REG_ATTACK_COEF:   prdata = CFG_DATA_W'(attack_coef_r);
      REG_ATTACK_BASE:   prdata = CFG_DATA_W'(attack_base_r);
      REG_DECAY_COEF:    prdata = CFG_DATA_W'(decay_coef_r);
      REG_DECAY_BASE:    prdata = CFG_DATA_W'(decay_base_r);
      REG_SUSTAIN_LEVEL: prdata = CFG_DATA_W'(sustain_level_r);
      REG_RELEASE_COEF:  prdata = CFG_DATA_W'(release_coef_r);
      REG_RELEASE_BASE:  prdata = CFG_DATA_W'(release_base_r);
      REG_LEAK_FACTOR:   prdata = CFG_DATA_W'(leak_factor_r);
      default:           prdata = '0;
    endcase
  end

  assign attack_coef   = attack_coef_r;
  assign attack_base   = attack_base_r;
  assign decay_coef    = decay_coef_r;
  assign decay_base    = decay_base_r;
  assign sustain_level = sustain_level_r;
  assign release_coef  = release_coef_r;
  assign release_base  = release_base_r;
  assign leak_factor   = leak_factor_r;

endmodule

`default_nettype wire

// ===== hdl/adsr_ctrl.sv =====
`default_nettype none

`include "adsr_envelope_generator_defines.svh"

module adsr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_req_type,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output adsr_pkg::dp_cmd_t       cmd,
  input  wire adsr_pkg::dp_stat_t stat
);
  import adsr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencing of one word
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_OUTMUL;
          case (in_req_type)
            REQ_TICK: begin
              if (stat.stage != ST_IDLE) state_nxt = S_MUL1;
            end
            REQ_NOTE_ON:  cmd.note_on  = 1'b1;
            REQ_NOTE_OFF: cmd.note_off = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LEVEL_COEF;
        state_nxt   = (stat.stage == ST_DECAY) ? S_MUL2 : S_UPD;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PROD_LEAK;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.upd_en = 1'b1;
        state_nxt  = S_OUTMUL;
      end
      S_OUTMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LEVEL_GAIN;
        state_nxt   = S_WB;
      end
      S_WB: begin
        // load output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  // Checks
  `ADSR_ASSERT_NXT(a_tick_runs_update, in_valid && in_ready && (in_req_type == REQ_TICK) && (stat.stage != ST_IDLE), state_r == S_MUL1, "active tick did not start update")
  `ADSR_ASSERT_IMP(a_mul2_after_mul1, state_r == S_MUL2, ($past(state_r) == S_MUL1) && (stat.stage == ST_DECAY), "second product outside decay")
  `ADSR_ASSERT_NXT(a_wb_holds, (state_r == S_WB) && out_valid_r && !out_ready, state_r == S_WB, "result overwrote a pending word")

endmodule

`default_nettype wire

// ===== hdl/adsr_dp.sv =====
`default_nettype none

`include "adsr_envelope_generator_defines.svh"

module adsr_dp #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire adsr_pkg::dp_cmd_t          cmd,
  output adsr_pkg::dp_stat_t              stat,
  input  wire logic        [FRAC_BITS:0]   in_velocity,
  input  wire logic        [FRAC_BITS:0]   attack_coef,
  input  wire logic        [FRAC_BITS:0]   attack_base,
  input  wire logic        [FRAC_BITS:0]   decay_coef,
  input  wire logic signed [FRAC_BITS+1:0] decay_base,
  input  wire logic        [FRAC_BITS:0]   sustain_level,
  input  wire logic        [FRAC_BITS:0]   release_coef,
  input  wire logic signed [FRAC_BITS:0]   release_base,
  input  wire logic        [FRAC_BITS:0]   leak_factor,
  output logic             [FRAC_BITS:0]   out_env_out,
  output logic             [2:0]           out_stage
);
  import adsr_pkg::*;

  localparam int UW = FRAC_BITS + 1;  // unsigned Q value
  localparam int LW = FRAC_BITS + 3;  // level, signed, [-1.0, 2.0)
  localparam int MW = FRAC_BITS + 4;  // multiplier operand magnitude
  localparam int AW = FRAC_BITS + 5;  // multiplier operand / product, signed
  localparam int PW = MW + UW;        // raw product
  localparam int SW = FRAC_BITS + 6;  // update sum, signed

  localparam logic [UW-1:0]        ONE_U  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] ONE_S  = SW'(longint'(1) <<< FRAC_BITS);
  localparam logic signed [SW-1:0] LMAX_S = SW'((longint'(1) <<< (FRAC_BITS + 1)) - 1);
  localparam logic signed [SW-1:0] LMIN_S = SW'(-(longint'(1) <<< FRAC_BITS));
  localparam logic signed [SW-1:0] ZERO_S = '0;
  localparam logic signed [AW-1:0] ONE_A  = AW'(longint'(1) <<< FRAC_BITS);
  localparam logic [PW-1:0]        HALF_P = PW'(longint'(1) <<< (FRAC_BITS - 1));

  stage_t                 stage_r, stage_nxt;
  logic signed [LW-1:0]   level_r, level_nxt;
  logic        [UW-1:0]   gain_r, gain_nxt;
  logic signed [AW-1:0]   prod_r;
  logic        [UW-1:0]   env_out_r;
  stage_t                 out_stage_r;

  logic signed [AW-1:0]   mul_a;
  logic        [UW-1:0]   mul_b;
  logic        [UW-1:0]   stage_coef;
  logic                   a_neg;
  logic        [MW-1:0]   a_mag;
  logic        [PW-1:0]   prod_raw;
  logic        [PW-1:0]   prod_rnd;
  logic signed [AW-1:0]   rnd_mag;
  logic signed [AW-1:0]   mul_res;

  logic signed [SW-1:0]   base_s;
  logic signed [SW-1:0]   sum_s;
  logic signed [SW-1:0]   sat_s;
  logic signed [SW-1:0]   sus_s;

  // Feedback coefficient of the current stage
  always_comb begin
    case (stage_r)
      ST_ATTACK:  stage_coef = attack_coef;
      ST_DECAY:   stage_coef = decay_coef;
      ST_SUSTAIN: stage_coef = leak_factor;
      ST_RELEASE: stage_coef = release_coef;
      default:    stage_coef = '0;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MS_LEVEL_COEF: begin
        mul_a = AW'(level_r);
        mul_b = stage_coef;
      end
      MS_PROD_LEAK: begin
        mul_a = prod_r;
        mul_b = leak_factor;
      end
      MS_LEVEL_GAIN: begin
        mul_a = AW'(level_r);
        mul_b = gain_r;
      end
      default: begin
        mul_a = AW'(level_r);
        mul_b = '0;
      end
    endcase
  end

  // Sign-magnitude Q product, rounded half away from zero
  always_comb begin
    a_neg    = mul_a[AW-1];
    a_mag    = MW'(a_neg ? -mul_a : mul_a);
    prod_raw = PW'(a_mag) * PW'(mul_b);
    prod_rnd = prod_raw + HALF_P;
    rnd_mag  = signed'(prod_rnd[FRAC_BITS +: AW]);
    mul_res  = a_neg ? -rnd_mag : rnd_mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_res;
  end

  // Stage base plus product, saturated, then the stage end checks
  always_comb begin
    case (stage_r)
      ST_ATTACK:  base_s = signed'({{(SW-UW){1'b0}}, attack_base});
      ST_DECAY:   base_s = SW'(decay_base);
      ST_RELEASE: base_s = SW'(release_base);
      default:    base_s = '0;
    endcase
    sum_s = base_s + SW'(prod_r);
    if (sum_s > LMAX_S)      sat_s = LMAX_S;
    else if (sum_s < LMIN_S) sat_s = LMIN_S;
    else                     sat_s = sum_s;
    sus_s = signed'({{(SW-UW){1'b0}}, sustain_level});
  end

  // Envelope state next values
  always_comb begin
    stage_nxt = stage_r;
    level_nxt = level_r;
    gain_nxt  = gain_r;
    if (cmd.note_on) begin
      stage_nxt = ST_ATTACK;
      gain_nxt  = in_velocity;
    end else if (cmd.note_off && (stage_r != ST_IDLE)) begin
      stage_nxt = ST_RELEASE;
    end else if (cmd.upd_en) begin
      level_nxt = LW'(sat_s);
      case (stage_r)
        ST_ATTACK: begin
          if (sat_s >= ONE_S) begin
            level_nxt = LW'(ONE_S);
            stage_nxt = ST_DECAY;
          end
        end
        ST_DECAY: begin
          if (sat_s <= sus_s) begin
            level_nxt = LW'(sus_s);
            stage_nxt = ST_SUSTAIN;
          end
        end
        ST_RELEASE: begin
          // signed compare: any level at or below zero ends the release
          if (sat_s <= ZERO_S) begin
            level_nxt = '0;
            stage_nxt = ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_IDLE;
      level_r <= '0;
      gain_r  <= ONE_U;
    end else begin
      stage_r <= stage_nxt;
      level_r <= level_nxt;
      gain_r  <= gain_nxt;
    end
  end

  // Output word: level*gain clamped to [0, 1.0]
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (prod_r < 0)          env_out_r <= '0;
      else if (prod_r > ONE_A) env_out_r <= ONE_U;
      else                     env_out_r <= prod_r[UW-1:0];
      out_stage_r <= stage_r;
    end
  end

  assign stat.stage  = stage_r;
  assign out_env_out = env_out_r;
  assign out_stage   = out_stage_r;

  // Checks
  `ADSR_ASSERT_IMP(a_idle_level_zero, stage_r == ST_IDLE, level_r == '0, "idle with nonzero level")
  `ADSR_ASSERT_IMP(a_level_floor, 1'b1, SW'(level_r) >= LMIN_S, "level below -1.0")
  `ADSR_ASSERT_NXT(a_note_on_attack, cmd.note_on, stage_r == ST_ATTACK, "note on did not enter attack")

endmodule

`default_nettype wire

// ===== hdl/adsr_envelope_generator.sv =====
`default_nettype none

// Exponential ADSR envelope generator. Each input word is a sample tick, a
// note-on carrying a velocity, or a note-off; each one yields exactly one
// output word with level*gain (clamped to [0, 1.0], Q1.FRAC_BITS) and the
// stage after the word. Words are handled one at a time by a sequencer
// around a single shared multiplier. An active-stage tick runs a product
// (two in decay), the update, the output product and the writeback; a
// note-on, a note-off or an idle tick runs only the output product and
// writeback. The output register lets the next word enter while a result
// is still waiting to be taken. Registers sit on the APB port at byte
// address 4*index and should only be written while no word is in flight.

module adsr_envelope_generator #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_req_type,
  input  wire logic [FRAC_BITS:0]              in_velocity,
  // output words
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [FRAC_BITS:0]              out_env_out,
  output logic      [2:0]                      out_stage,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [adsr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [adsr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import adsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic        [FRAC_BITS:0]   attack_coef;
  logic        [FRAC_BITS:0]   attack_base;
  logic        [FRAC_BITS:0]   decay_coef;
  logic signed [FRAC_BITS+1:0] decay_base;
  logic        [FRAC_BITS:0]   sustain_level;
  logic        [FRAC_BITS:0]   release_coef;
  logic signed [FRAC_BITS:0]   release_base;
  logic        [FRAC_BITS:0]   leak_factor;

  adsr_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .attack_coef   (attack_coef),
    .attack_base   (attack_base),
    .decay_coef    (decay_coef),
    .decay_base    (decay_base),
    .sustain_level (sustain_level),
    .release_coef  (release_coef),
    .release_base  (release_base),
    .leak_factor   (leak_factor)
  );

  adsr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  adsr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_velocity   (in_velocity),
    .attack_coef   (attack_coef),
    .attack_base   (attack_base),
    .decay_coef    (decay_coef),
    .decay_base    (decay_base),
    .sustain_level (sustain_level),
    .release_coef  (release_coef),
    .release_base  (release_base),
    .leak_factor   (leak_factor),
    .out_env_out   (out_env_out),
    .out_stage     (out_stage)
  );

endmodule

`default_nettype wire
